/* rtl/fsp_pkg.sv */
`timescale 1ns / 1ps
package fsp_pkg;

	// characters that carry meaning in a conversion spec
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_P     = 8'h70;

	// flag bit positions
	localparam logic [3:0] FLG_MINUS = 4'd0;
	localparam logic [3:0] FLG_PLUS  = 4'd1;
	localparam logic [3:0] FLG_SPACE = 4'd2;
	localparam logic [3:0] FLG_HASH  = 4'd3;
	localparam logic [3:0] FLG_ZERO  = 4'd4;

	// length codes
	localparam logic [1:0] LEN_NONE = 2'd0;
	localparam logic [1:0] LEN_H    = 2'd1;
	localparam logic [1:0] LEN_L    = 2'd2;

	// specifier codes
	localparam logic [3:0] SPC_D  = 4'd0;
	localparam logic [3:0] SPC_I  = 4'd1;
	localparam logic [3:0] SPC_O  = 4'd2;
	localparam logic [3:0] SPC_U  = 4'd3;
	localparam logic [3:0] SPC_XL = 4'd4;
	localparam logic [3:0] SPC_XU = 4'd5;
	localparam logic [3:0] SPC_C  = 4'd6;
	localparam logic [3:0] SPC_S  = 4'd7;
	localparam logic [3:0] SPC_P  = 4'd8;

	localparam int MID_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 2;

	typedef struct packed {
		logic [7:0] char_in;
		logic       start_req;
	} in_item_t;

	typedef struct packed {
		logic        flag_minus;
		logic        flag_plus;
		logic        flag_space;
		logic        flag_hash;
		logic        flag_zero;
		logic [15:0] field_width;
		logic [15:0] prec_value;
		logic        prec_given;
		logic [1:0]  length_code;
		logic [3:0]  spec_code;
		logic [7:0]  consumed;
		logic        bad_spec;
	} result_t;

	// byte classes as seen by the back end
	typedef enum logic [2:0] {
		K_FLAG,   // - + space #
		K_ZERO,   // '0': flag or digit depending on phase
		K_DIGIT,  // 1..9
		K_DOT,
		K_LEN,
		K_SPEC,
		K_OTHER
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] arg;    // flag index, digit value, length code or specifier code
		logic       start;
	} token_t;

endpackage

/* rtl/format_spec_parser_top.sv */
`timescale 1ns / 1ps
// Path: front stage register, token queue, back end, result queue, result ports.
// Throughput: one byte per cycle unless a queue is full; the back end takes a token
// each cycle the result queue has room, pushing a result with the byte that ends it.
// Reset: arst_n is asynchronous, active low; it empties both queues and returns the
// parser to the flags phase with all fields cleared.
module format_spec_parser_top #(
	parameter int MID_DEPTH = fsp_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH = fsp_pkg::OUT_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fsp_pkg::in_item_t item,
	output logic              full,
	input  logic              pop,
	output fsp_pkg::result_t  result,
	output logic              empty
);

	localparam int TW = $bits(fsp_pkg::token_t);
	localparam int RW = $bits(fsp_pkg::result_t);

	logic             f_valid, mid_full, mid_empty, mid_pop;
	fsp_pkg::token_t  f_tok, b_tok;
	logic [TW-1:0]    mid_rdata;
	logic             res_full, res_push;
	fsp_pkg::result_t b_res;
	logic [RW-1:0]    out_rdata;

	fsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.tok_valid (f_valid),
		.tok       (f_tok),
		.tok_full  (mid_full)
	);

	fsp_queue #(
		.WIDTH (TW),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.wdata  (f_tok),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign b_tok = fsp_pkg::token_t'(mid_rdata);

	fsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_empty (mid_empty),
		.tok       (b_tok),
		.tok_pop   (mid_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (b_res)
	);

	fsp_queue #(
		.WIDTH (RW),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (b_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign result = fsp_pkg::result_t'(out_rdata);

endmodule

/* rtl/fsp_queue.sv */
`timescale 1ns / 1ps
module fsp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count beyond depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a write");

endmodule

/* rtl/fsp_front.sv */
`timescale 1ns / 1ps
module fsp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fsp_pkg::in_item_t item,
	output logic              full,
	output logic              tok_valid,
	output fsp_pkg::token_t   tok,
	input  logic              tok_full
);

	logic            valid_s1;
	fsp_pkg::token_t tok_s1;
	fsp_pkg::token_t cls;
	logic            take;

	always_comb begin
		cls.start = item.start_req;
		cls.kind  = fsp_pkg::K_OTHER;
		cls.arg   = '0;
		case (item.char_in)
			fsp_pkg::CH_MINUS: begin cls.kind = fsp_pkg::K_FLAG; cls.arg = fsp_pkg::FLG_MINUS; end
			fsp_pkg::CH_PLUS:  begin cls.kind = fsp_pkg::K_FLAG; cls.arg = fsp_pkg::FLG_PLUS;  end
			fsp_pkg::CH_SPACE: begin cls.kind = fsp_pkg::K_FLAG; cls.arg = fsp_pkg::FLG_SPACE; end
			fsp_pkg::CH_HASH:  begin cls.kind = fsp_pkg::K_FLAG; cls.arg = fsp_pkg::FLG_HASH;  end
			fsp_pkg::CH_ZERO:  begin cls.kind = fsp_pkg::K_ZERO; cls.arg = fsp_pkg::FLG_ZERO;  end
			fsp_pkg::CH_DOT:   cls.kind = fsp_pkg::K_DOT;
			fsp_pkg::CH_H:     begin cls.kind = fsp_pkg::K_LEN;  cls.arg = {2'b00, fsp_pkg::LEN_H}; end
			fsp_pkg::CH_L:     begin cls.kind = fsp_pkg::K_LEN;  cls.arg = {2'b00, fsp_pkg::LEN_L}; end
			fsp_pkg::CH_D:     begin cls.kind = fsp_pkg::K_SPEC; cls.arg = fsp_pkg::SPC_D;  end
			fsp_pkg::CH_I:     begin cls.kind = fsp_pkg::K_SPEC; cls.arg = fsp_pkg::SPC_I;  end
			fsp_pkg::CH_O:     begin cls.kind = fsp_pkg::K_SPEC; cls.arg = fsp_pkg::SPC_O;  end
			fsp_pkg::CH_U:     begin cls.kind = fsp_pkg::K_SPEC; cls.arg = fsp_pkg::SPC_U;  end
			fsp_pkg::CH_X_LO:  begin cls.kind = fsp_pkg::K_SPEC; cls.arg = fsp_pkg::SPC_XL; end
			fsp_pkg::CH_X_UP:  begin cls.kind = fsp_pkg::K_SPEC; cls.arg = fsp_pkg::SPC_XU; end
			fsp_pkg::CH_C:     begin cls.kind = fsp_pkg::K_SPEC; cls.arg = fsp_pkg::SPC_C;  end
			fsp_pkg::CH_S:     begin cls.kind = fsp_pkg::K_SPEC; cls.arg = fsp_pkg::SPC_S;  end
			fsp_pkg::CH_P:     begin cls.kind = fsp_pkg::K_SPEC; cls.arg = fsp_pkg::SPC_P;  end
			default: begin
				if (item.char_in > fsp_pkg::CH_ZERO && item.char_in <= fsp_pkg::CH_NINE) begin
					cls.kind = fsp_pkg::K_DIGIT;
					cls.arg  = item.char_in[3:0];
				end
			end
		endcase
	end

	// stage empties into the queue whenever the queue has room
	assign full      = valid_s1 && tok_full;
	assign take      = push && !full;
	assign tok_valid = valid_s1;
	assign tok       = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!tok_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_s1 <= cls;
		end
	end

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && tok_full) |=> (valid_s1 && $stable(tok_s1)))
		else $error("stalled token lost or changed");

endmodule

/* rtl/fsp_back.sv */
`timescale 1ns / 1ps
module fsp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tok_empty,
	input  fsp_pkg::token_t  tok,
	output logic             tok_pop,
	input  logic             res_full,
	output logic             res_push,
	output fsp_pkg::result_t res
);

	typedef enum logic [1:0] {
		PH_FLAGS,
		PH_WIDTH,
		PH_PREC,
		PH_LEN
	} phase_t;

	phase_t      phase_q, phase_b, phase_d;
	logic [4:0]  flags_q, flags_b, flags_d;
	logic [15:0] width_q, width_b, width_d;
	logic [15:0] prec_q, prec_b, prec_d;
	logic        seen_q, seen_b, seen_d;
	logic [1:0]  len_q, len_b, len_d;
	logic [7:0]  count_q, count_b, count_d;
	logic        emit, bad;
	logic [3:0]  spec;
	logic [4:0]  flag_bit;

	function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [3:0] d);
		logic [19:0] v;
		v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 20'(d);
		return (v > 20'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	assign tok_pop  = !tok_empty && !res_full;
	assign flag_bit = 5'(1) << tok.arg[2:0];

	always_comb begin
		// a start request clears the state ahead of this byte
		if (tok.start) begin
			phase_b = PH_FLAGS;
			flags_b = '0;
			width_b = '0;
			prec_b  = '0;
			seen_b  = 1'b0;
			len_b   = fsp_pkg::LEN_NONE;
			count_b = '0;
		end else begin
			phase_b = phase_q;
			flags_b = flags_q;
			width_b = width_q;
			prec_b  = prec_q;
			seen_b  = seen_q;
			len_b   = len_q;
			count_b = count_q;
		end
		phase_d = phase_b;
		flags_d = flags_b;
		width_d = width_b;
		prec_d  = prec_b;
		seen_d  = seen_b;
		len_d   = len_b;
		count_d = (count_b == 8'hFF) ? count_b : count_b + 1'b1;
		emit    = 1'b0;
		bad     = 1'b0;
		spec    = fsp_pkg::SPC_D;

		if (phase_b == PH_FLAGS &&
		    (tok.kind == fsp_pkg::K_FLAG || tok.kind == fsp_pkg::K_ZERO)) begin
			flags_d = flags_b | flag_bit;
		end else if ((tok.kind == fsp_pkg::K_DIGIT || tok.kind == fsp_pkg::K_ZERO) &&
		             (phase_b == PH_FLAGS || phase_b == PH_WIDTH)) begin
			width_d = add_digit(width_b, (tok.kind == fsp_pkg::K_ZERO) ? 4'd0 : tok.arg);
			phase_d = PH_WIDTH;
		end else if ((tok.kind == fsp_pkg::K_DIGIT || tok.kind == fsp_pkg::K_ZERO) &&
		             phase_b == PH_PREC) begin
			prec_d = add_digit(prec_b, (tok.kind == fsp_pkg::K_ZERO) ? 4'd0 : tok.arg);
		end else if (tok.kind == fsp_pkg::K_DOT &&
		             (phase_b == PH_FLAGS || phase_b == PH_WIDTH)) begin
			seen_d  = 1'b1;
			phase_d = PH_PREC;
		end else if (tok.kind == fsp_pkg::K_LEN && phase_b != PH_LEN) begin
			len_d   = tok.arg[1:0];
			phase_d = PH_LEN;
		end else if (tok.kind == fsp_pkg::K_SPEC) begin
			emit = 1'b1;
			spec = tok.arg;
		end else begin
			// rejected byte is not counted
			emit    = 1'b1;
			bad     = 1'b1;
			count_d = count_b;
		end

		res.flag_minus  = flags_d[0];
		res.flag_plus   = flags_d[1];
		res.flag_space  = flags_d[2];
		res.flag_hash   = flags_d[3];
		res.flag_zero   = flags_d[4];
		res.field_width = width_d;
		res.prec_value  = prec_d;
		res.prec_given  = seen_d;
		res.length_code = len_d;
		res.spec_code   = spec;
		res.consumed    = count_d;
		res.bad_spec    = bad;
	end

	assign res_push = tok_pop && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAGS;
			flags_q <= '0;
			width_q <= '0;
			prec_q  <= '0;
			seen_q  <= 1'b0;
			len_q   <= fsp_pkg::LEN_NONE;
			count_q <= '0;
		end else if (tok_pop) begin
			if (emit) begin
				phase_q <= PH_FLAGS;
				flags_q <= '0;
				width_q <= '0;
				prec_q  <= '0;
				seen_q  <= 1'b0;
				len_q   <= fsp_pkg::LEN_NONE;
				count_q <= '0;
			end else begin
				phase_q <= phase_d;
				flags_q <= flags_d;
				width_q <= width_d;
				prec_q  <= prec_d;
				seen_q  <= seen_d;
				len_q   <= len_d;
				count_q <= count_d;
			end
		end
	end

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (count_q == '0 && phase_q == PH_FLAGS && flags_q == '0))
		else $error("state not cleared after a result");
	a_width_only_in_width_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FLAGS) |-> (width_q == '0 && !seen_q && len_q == fsp_pkg::LEN_NONE))
		else $error("flags phase with parsed width, dot or length");

endmodule
